// ===== rtl/tsp_pkg.sv =====
package tsp_pkg;

  // Field widths of the item payloads
  localparam int SPEED_W   = 24;
  localparam int RATE_W    = 27;
  localparam int STEPS_W   = 32;
  localparam int PERIOD_W  = 16;
  localparam int CMP_W     = 15;
  localparam int PHASE_W   = 2;
  localparam int SPEED_FRAC = 8;

  // Defaults for the top-level parameters
  localparam int STEP_BITS_DEF  = 32;
  localparam int PERIOD_MAX_DEF = 65535;
  localparam int PERIOD_MIN_DEF = 100;

  // Register reset values
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 24'd25600;
  localparam logic [RATE_W-1:0]  TIMER_RATE_RST = 27'd1800000;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE = 1'd1;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Motion phases
  localparam logic [PHASE_W-1:0] PH_STOP   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [SPEED_W-1:0] cruise_speed;
    logic [STEPS_W-1:0] move_steps;
    logic [STEPS_W-1:0] ramp_up_steps;
    logic [STEPS_W-1:0] ramp_down_steps;
    logic               direction;
  } tsp_in_t;

  typedef struct packed {
    logic                accepted;
    logic [PHASE_W-1:0]  phase;
    logic [PERIOD_W-1:0] period;
    logic [CMP_W-1:0]    compare;
    logic                dir_out;
    logic                drive_enable;
    logic                done_res;
  } tsp_out_t;

endpackage

// ===== rtl/tsp_divider.sv =====
module tsp_divider #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  // Bring down the next dividend bit and try the subtract
  assign trial     = {rem, quo[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits      = (trial >= {1'b0, den});
  assign quotient  = quo;

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        den  <= divisor;
        quo  <= dividend;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Done only closes a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  // Count stays inside the iteration range
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt < CNT_W'(NUM_W)))
    else $error("divider count out of range");

  // A fresh start leaves the divider busy and not yet done
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    go |=> busy && !done)
    else $error("divider did not start");

endmodule

// ===== rtl/trapezoid_step_profile.sv =====
// Trapezoidal stepper speed profile. A start item (kind 0) loads a move while
// stopped; each step tick (kind 1) advances the step count, phase and speed.
// Every item gives one result with the timer period timer_rate*256/speed,
// clamped to PERIOD_MIN..PERIOD_MAX, and half of it as compare. All divisions
// run on one shared radix-2 divider that retires one quotient bit per cycle
// over a 35-bit dividend: a tick or an ignored item runs one period division,
// a start two rate divisions and then one period division, and the next item
// is taken once the result sits in the output register. One item is in
// work at a time; the next item is taken while the previous result still
// waits in the output register, and a result that finds that register full
// holds the block until the receiver takes the older one.
module trapezoid_step_profile #(
  parameter int STEP_BITS  = tsp_pkg::STEP_BITS_DEF,
  parameter int PERIOD_MAX = tsp_pkg::PERIOD_MAX_DEF,
  parameter int PERIOD_MIN = tsp_pkg::PERIOD_MIN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tsp_pkg::tsp_in_t                   in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tsp_pkg::tsp_out_t                  out_item,
  input  logic                               cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tsp_pkg::*;

  localparam int DIV_DEN_W = (STEP_BITS > SPEED_W) ? STEP_BITS : SPEED_W;
  localparam int DIV_NUM_W = RATE_W + SPEED_FRAC;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RISE = 3'd1;
  localparam logic [2:0] S_FALL = 3'd2;
  localparam logic [2:0] S_PER  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           state;
  logic [SPEED_W-1:0]   base_speed;
  logic [RATE_W-1:0]    timer_rate;
  logic [PHASE_W-1:0]   motion_phase;
  logic [STEP_BITS-1:0] step_count;
  logic [STEP_BITS-1:0] goal_steps;
  logic [STEP_BITS-1:0] accel_count;
  logic [STEP_BITS-1:0] decel_count;
  logic [STEP_BITS-1:0] ramp_edge;
  logic [SPEED_W-1:0]   speed_now;
  logic [SPEED_W-1:0]   speed_target;
  logic [SPEED_W-1:0]   rise_rate;
  logic [SPEED_W-1:0]   fall_rate;
  logic                 dir_latched;
  logic                 res_accepted;
  logic                 res_done;
  logic [PERIOD_W-1:0]  period_clamp;

  logic                 div_go;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;

  logic [STEP_BITS-1:0] tot;
  logic [STEP_BITS-1:0] up;
  logic [STEP_BITS-1:0] down;
  logic [STEP_BITS:0]   ramp_sum;
  logic                 ramps_long;
  logic [STEP_BITS-1:0] half_steps;
  logic [STEP_BITS-1:0] rest_steps;
  logic [SPEED_W-1:0]   tgt_fix;
  logic [SPEED_W-1:0]   speed_diff;
  logic [STEP_BITS-1:0] cnt_inc;
  logic [SPEED_W:0]     speed_up;
  logic [SPEED_W-1:0]   speed_up_sat;
  logic [SPEED_W-1:0]   speed_dn;
  logic [SPEED_W-1:0]   speed_dn_floor;
  logic [SPEED_W-1:0]   rate_q;
  logic [PERIOD_W-1:0]  period_clamp_next;
  logic                 out_load;

  assign in_ready = (state == S_IDLE);

  // Load the output register once it is free
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Start item: split the ramps and raise the target
  assign tot        = in_item.move_steps[STEP_BITS-1:0];
  assign up         = in_item.ramp_up_steps[STEP_BITS-1:0];
  assign down       = in_item.ramp_down_steps[STEP_BITS-1:0];
  assign ramp_sum   = {1'b0, up} + {1'b0, down};
  assign ramps_long = (ramp_sum >= {1'b0, tot});
  assign half_steps = tot >> 1;
  assign rest_steps = tot - half_steps;
  assign tgt_fix    = (in_item.cruise_speed < base_speed) ? base_speed
                                                          : in_item.cruise_speed;
  assign speed_diff = speed_target - base_speed;

  // Step tick: next count and candidate speeds
  assign cnt_inc        = step_count + 1'b1;
  assign speed_up       = {1'b0, speed_now} + {1'b0, rise_rate};
  assign speed_up_sat   = speed_up[SPEED_W] ? {SPEED_W{1'b1}} : speed_up[SPEED_W-1:0];
  assign speed_dn       = (speed_now >= fall_rate) ? (speed_now - fall_rate) : '0;
  assign speed_dn_floor = (speed_dn < base_speed) ? base_speed : speed_dn;

  // Route the divider operands by step of the sequence
  always_comb begin
    case (state)
      S_RISE: begin
        div_num = DIV_NUM_W'(speed_diff);
        div_den = DIV_DEN_W'(accel_count);
      end
      S_FALL: begin
        div_num = DIV_NUM_W'(speed_diff);
        div_den = DIV_DEN_W'(decel_count);
      end
      default: begin
        div_num = {timer_rate, {SPEED_FRAC{1'b0}}};
        div_den = DIV_DEN_W'(speed_now);
      end
    endcase
  end

  assign rate_q = div_quo[SPEED_W-1:0];

  // Clamp the period, upper bound first
  always_comb begin
    if (div_quo > DIV_NUM_W'(PERIOD_MAX)) begin
      period_clamp_next = PERIOD_W'(PERIOD_MAX);
    end else if (div_quo < DIV_NUM_W'(PERIOD_MIN)) begin
      period_clamp_next = PERIOD_W'(PERIOD_MIN);
    end else begin
      period_clamp_next = div_quo[PERIOD_W-1:0];
    end
  end

  tsp_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequence one item through update, divisions and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_go       <= 1'b0;
      out_valid    <= 1'b0;
      base_speed   <= BASE_SPEED_RST;
      timer_rate   <= TIMER_RATE_RST;
      motion_phase <= PH_STOP;
      step_count   <= '0;
      goal_steps   <= '0;
      accel_count  <= '0;
      decel_count  <= '0;
      ramp_edge    <= '0;
      speed_now    <= '0;
      speed_target <= '0;
      rise_rate    <= '0;
      fall_rate    <= '0;
      dir_latched  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_SPEED: base_speed <= cfg_data[SPEED_W-1:0];
          CFG_TIMER_RATE: timer_rate <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            div_go       <= 1'b1;
            res_accepted <= 1'b0;
            res_done     <= 1'b0;
            state        <= S_PER;
            if (in_item.kind == KIND_START && motion_phase == PH_STOP) begin
              res_accepted <= 1'b1;
              goal_steps   <= tot;
              step_count   <= '0;
              speed_now    <= base_speed;
              speed_target <= tgt_fix;
              accel_count  <= ramps_long ? half_steps : up;
              decel_count  <= ramps_long ? rest_steps : down;
              dir_latched  <= in_item.direction;
              motion_phase <= PH_ACCEL;
              state        <= S_RISE;
            end else if (in_item.kind == KIND_TICK && motion_phase != PH_STOP) begin
              res_accepted <= 1'b1;
              step_count   <= cnt_inc;
              if (cnt_inc >= goal_steps) begin
                motion_phase <= PH_STOP;
                res_done     <= 1'b1;
              end else if (cnt_inc <= accel_count) begin
                motion_phase <= PH_ACCEL;
                speed_now    <= speed_up_sat;
              end else if (cnt_inc >= ramp_edge) begin
                motion_phase <= PH_DECEL;
                speed_now    <= speed_dn_floor;
              end else begin
                motion_phase <= PH_CRUISE;
                speed_now    <= speed_target;
              end
            end
          end
        end
        S_RISE: begin
          if (div_done) begin
            rise_rate <= (accel_count == '0) ? speed_diff : rate_q;
            ramp_edge <= (decel_count > goal_steps) ? '0 : (goal_steps - decel_count);
            div_go    <= 1'b1;
            state     <= S_FALL;
          end
        end
        S_FALL: begin
          if (div_done) begin
            fall_rate <= (decel_count == '0) ? speed_diff : rate_q;
            div_go    <= 1'b1;
            state     <= S_PER;
          end
        end
        S_PER: begin
          if (div_done) begin
            period_clamp <= period_clamp_next;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            out_item.accepted     <= res_accepted;
            out_item.phase        <= motion_phase;
            out_item.period       <= period_clamp;
            out_item.compare      <= period_clamp[PERIOD_W-1:1];
            out_item.dir_out      <= dir_latched;
            out_item.drive_enable <= (motion_phase != PH_STOP);
            out_item.done_res     <= res_done;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item always starts the sequence
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RISE || state == S_PER))
    else $error("accepted item did not start a division");

  // Divider finishes only while the sequence waits on it
  a_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RISE || state == S_FALL || state == S_PER))
    else $error("divider result arrived outside a division step");

  // A new result comes only from the output step
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output step");

  // A completing tick reports a stopped, accepted move
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.done_res) |-> (out_item.accepted && out_item.phase == PH_STOP))
    else $error("completed move not reported as stopped");

endmodule

// ===== tb/trapezoid_step_profile_test.sv =====
module trapezoid_step_profile_test;
  import tsp_pkg::*;

  localparam int PER_MAX = PERIOD_MAX_DEF;
  localparam int PER_MIN = PERIOD_MIN_DEF;
  localparam int ITEM_TARGET = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_LIMIT = 40;
  localparam logic [SPEED_W-1:0] SPEED_TOP = '1;
  localparam logic [STEPS_W-1:0] STEPS_TOP = '1;
  localparam logic [RATE_W-1:0] RATE_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tsp_in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tsp_out_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies and motion state of the profile predictor
  logic [SPEED_W-1:0] base_speed_reg;
  logic [RATE_W-1:0] timer_rate_reg;
  logic [PHASE_W-1:0] mv_phase;
  logic [STEPS_W-1:0] mv_count, mv_goal, mv_up, mv_down;
  logic [SPEED_W-1:0] mv_speed, mv_target, mv_rise, mv_fall;
  logic mv_dir;

  tsp_out_t timing_q[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit burst = 1'b0;
  bit hold_req = 1'b0;

  trapezoid_step_profile dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Timer period for a speed, clamped; zero speed gives the longest period
  function automatic logic [PERIOD_W-1:0] timer_period(logic [SPEED_W-1:0] speed);
    logic [63:0] q;
    if (speed == '0) return PERIOD_W'(PER_MAX);
    q = (64'(timer_rate_reg) << SPEED_FRAC) / 64'(speed);
    if (q > 64'(PER_MAX)) q = 64'(PER_MAX);
    if (q < 64'(PER_MIN)) q = 64'(PER_MIN);
    return q[PERIOD_W-1:0];
  endfunction

  // Per-step speed change; a zero count takes the whole difference at once
  function automatic logic [SPEED_W-1:0] ramp_rate(logic [SPEED_W-1:0] diff,
                                                   logic [STEPS_W-1:0] count);
    logic [STEPS_W-1:0] r;
    r = (count == '0) ? STEPS_W'(diff) : STEPS_W'(diff) / count;
    return r[SPEED_W-1:0];
  endfunction

  function automatic tsp_out_t profile_result(logic acc, logic done);
    tsp_out_t r;
    logic [PERIOD_W-1:0] p;
    p = timer_period(mv_speed);
    r.accepted = acc;
    r.phase = mv_phase;
    r.period = p;
    r.compare = p[PERIOD_W-1:1];
    r.dir_out = mv_dir;
    r.drive_enable = (mv_phase != PH_STOP);
    r.done_res = done;
    return r;
  endfunction

  // Advance the motion state by one item and queue the timing it produces
  task automatic profile_step(input tsp_in_t item);
    logic [SPEED_W:0] sum;
    logic [SPEED_W-1:0] diff, s;
    logic [STEPS_W-1:0] edge_step;
    tsp_out_t r;
    if (item.kind == KIND_START) begin
      if (mv_phase != PH_STOP) begin
        r = profile_result(1'b0, 1'b0);
      end else begin
        mv_goal = item.move_steps;
        mv_count = '0;
        mv_speed = base_speed_reg;
        mv_target = (item.cruise_speed < base_speed_reg) ? base_speed_reg
                                                         : item.cruise_speed;
        if ({1'b0, item.ramp_up_steps} + {1'b0, item.ramp_down_steps} >=
            {1'b0, item.move_steps}) begin
          mv_up = item.move_steps >> 1;
          mv_down = item.move_steps - mv_up;
        end else begin
          mv_up = item.ramp_up_steps;
          mv_down = item.ramp_down_steps;
        end
        diff = mv_target - base_speed_reg;
        mv_rise = ramp_rate(diff, mv_up);
        mv_fall = ramp_rate(diff, mv_down);
        mv_dir = item.direction;
        mv_phase = PH_ACCEL;
        r = profile_result(1'b1, 1'b0);
      end
    end else if (mv_phase == PH_STOP) begin
      r = profile_result(1'b0, 1'b0);
    end else begin
      mv_count = mv_count + 1'b1;
      if (mv_count >= mv_goal) begin
        mv_phase = PH_STOP;
        r = profile_result(1'b1, 1'b1);
      end else begin
        edge_step = (mv_down > mv_goal) ? '0 : mv_goal - mv_down;
        if (mv_count <= mv_up) begin
          sum = {1'b0, mv_speed} + {1'b0, mv_rise};
          mv_phase = PH_ACCEL;
          mv_speed = sum[SPEED_W] ? SPEED_TOP : sum[SPEED_W-1:0];
        end else if (mv_count >= edge_step) begin
          s = (mv_speed >= mv_fall) ? mv_speed - mv_fall : '0;
          mv_phase = PH_DECEL;
          mv_speed = (s < base_speed_reg) ? base_speed_reg : s;
        end else begin
          mv_phase = PH_CRUISE;
          mv_speed = mv_target;
        end
        r = profile_result(1'b1, 1'b0);
      end
    end
    timing_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Mostly short stalls, now and then a long one
  function automatic int stall_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 12);
    if (r < 97) return $urandom_range(13, 40);
    return $urandom_range(60, 150);
  endfunction

  function automatic int pause_cycles();
    if (calm || burst) return 0;
    if ($urandom_range(0, 9) < 4) return 0;
    return stall_cycles();
  endfunction

  function automatic tsp_in_t tick_item();
    tsp_in_t item;
    item.kind = KIND_TICK;
    item.cruise_speed = SPEED_W'($urandom);
    item.move_steps = $urandom;
    item.ramp_up_steps = $urandom;
    item.ramp_down_steps = $urandom;
    item.direction = 1'($urandom_range(0, 1));
    return item;
  endfunction

  function automatic tsp_in_t start_item(logic [SPEED_W-1:0] tgt, logic [STEPS_W-1:0] total,
                                         logic [STEPS_W-1:0] up, logic [STEPS_W-1:0] down,
                                         logic dir);
    tsp_in_t item;
    item.kind = KIND_START;
    item.cruise_speed = tgt;
    item.move_steps = total;
    item.ramp_up_steps = up;
    item.ramp_down_steps = down;
    item.direction = dir;
    return item;
  endfunction

  // Start with every field random: ignored unless stopped
  function automatic tsp_in_t noise_start();
    return start_item(SPEED_W'($urandom), $urandom, $urandom, $urandom,
                      1'($urandom_range(0, 1)));
  endfunction

  // Start of a move short enough to run to completion
  function automatic tsp_in_t move_start();
    logic [STEPS_W-1:0] total, up, down;
    logic [SPEED_W-1:0] tgt;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) total = $urandom_range(0, 12);
    else if (r < 95) total = $urandom_range(13, 60);
    else total = $urandom_range(61, 200);
    up = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, total);
    down = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, total);
    r = $urandom_range(0, 9);
    if (r < 6) tgt = SPEED_W'($urandom);
    else if (r < 8) tgt = SPEED_W'($urandom_range(0, int'(base_speed_reg)));
    else tgt = (r == 8) ? '0 : SPEED_TOP;
    return start_item(tgt, total, up, down, 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_base_speed();
    logic [SPEED_W-1:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) v = '0;
    else if (r == 1) v = SPEED_TOP;
    else if (r < 7) v = SPEED_W'($urandom_range(256, 200000));
    else v = SPEED_W'($urandom);
    // upper data bits are don't-care for this register
    return {3'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_timer_rate();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return RATE_TOP;
    if (r < 6) return CFG_DATA_W'($urandom_range(1, 100000000));
    return CFG_DATA_W'($urandom_range(100000, 5000000));
  endfunction

  // Offer one item and hold it until it is taken
  task automatic send_item(input tsp_in_t item);
    int gap;
    gap = pause_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    profile_step(item);
    items_sent++;
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (timing_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_SPEED) base_speed_reg = data[SPEED_W-1:0];
    else timer_rate_reg = data[RATE_W-1:0];
  endtask

  // Run one move to completion, optionally mixed with ignored starts and
  // start speed changes mid-move
  task automatic run_move(input bit chaos);
    send_item(move_start());
    while (mv_phase != PH_STOP) begin
      if (chaos && $urandom_range(0, 19) == 0) send_item(noise_start());
      else if (chaos && $urandom_range(0, 39) == 0)
        write_reg(CFG_BASE_SPEED, rand_base_speed());
      else send_item(tick_item());
    end
    if ($urandom_range(0, 3) == 0) send_item(tick_item());
  endtask

  task automatic test_directed();
    send_item(tick_item());
    send_item(start_item(SPEED_TOP, 32'd4, 32'd1, 32'd1, 1'b1));
    send_item(start_item(24'd100, 32'd9, 32'd0, 32'd0, 1'b0));
    repeat (4) send_item(tick_item());
    send_item(tick_item());
    // empty move: the first tick completes it
    send_item(start_item('0, '0, '0, '0, 1'b0));
    send_item(tick_item());
    // ramps longer than the move, target below start speed
    send_item(start_item(24'd1000, 32'd5, 32'd3, 32'd3, 1'b1));
    repeat (5) send_item(tick_item());
    // no ramps: jump straight to the target
    send_item(start_item(24'h80_0000, 32'd3, 32'd0, 32'd0, 1'b0));
    repeat (3) send_item(tick_item());
  endtask

  task automatic test_register_sweep();
    logic [CFG_DATA_W-1:0] speeds[7];
    logic [CFG_DATA_W-1:0] rates[7];
    speeds = '{CFG_DATA_W'(BASE_SPEED_RST), '0, CFG_DATA_W'(SPEED_TOP), CFG_DATA_W'(256),
               CFG_DATA_W'(SPEED_TOP), '0, CFG_DATA_W'(1000)};
    rates = '{CFG_DATA_W'(TIMER_RATE_RST), '0, RATE_TOP, CFG_DATA_W'(1), '0, RATE_TOP,
              CFG_DATA_W'(100000000)};
    for (int i = 0; i < 7; i++) begin
      write_reg(CFG_BASE_SPEED, speeds[i]);
      write_reg(CFG_TIMER_RATE, rates[i]);
      run_move(1'b0);
      send_item(tick_item());
    end
  endtask

  // Stall the output long enough that the block backs up into its input
  task automatic test_backpressure();
    write_reg(CFG_BASE_SPEED, CFG_DATA_W'(BASE_SPEED_RST));
    write_reg(CFG_TIMER_RATE, CFG_DATA_W'(TIMER_RATE_RST));
    hold_req = 1'b1;
    wait (hold_req == 1'b0);
    burst = 1'b1;
    send_item(start_item(24'h01_0000, 32'd12, 32'd4, 32'd4, 1'b1));
    repeat (12) send_item(tick_item());
    burst = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET - 20) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_BASE_SPEED, rand_base_speed());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_TIMER_RATE, rand_timer_rate());
      run_move(1'b1);
    end
    calm = 1'b0;
  endtask

  // Longest possible move with ramps too long; it is never finished
  task automatic test_long_move();
    send_item(start_item(SPEED_W'($urandom), STEPS_TOP, STEPS_TOP, STEPS_TOP, 1'b1));
    repeat (8) send_item(tick_item());
    send_item(noise_start());
    repeat (3) send_item(tick_item());
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_result
    tsp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (timing_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item), '0);
      end else begin
        want = timing_q.pop_front();
        if (out_item.accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_item.accepted), 64'(want.accepted));
        if (out_item.phase !== want.phase)
          report_mismatch("phase", 64'(out_item.phase), 64'(want.phase));
        if (out_item.period !== want.period)
          report_mismatch("period", 64'(out_item.period), 64'(want.period));
        if (out_item.compare !== want.compare)
          report_mismatch("compare", 64'(out_item.compare), 64'(want.compare));
        if (out_item.dir_out !== want.dir_out)
          report_mismatch("dir_out", 64'(out_item.dir_out), 64'(want.dir_out));
        if (out_item.drive_enable !== want.drive_enable)
          report_mismatch("drive_enable", 64'(out_item.drive_enable),
                          64'(want.drive_enable));
        if (out_item.done_res !== want.done_res)
          report_mismatch("done_res", 64'(out_item.done_res), 64'(want.done_res));
      end
    end
  end

  // Receiver: random ready pattern, a long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (calm) begin
        out_ready <= 1'b1;
        n = 1;
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b0;
        n = stall_cycles();
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    #20000000;
    $display("[trapezoid_step_profile] ERROR");
    $finish;
  end

  initial begin
    base_speed_reg = BASE_SPEED_RST;
    timer_rate_reg = TIMER_RATE_RST;
    mv_phase = PH_STOP;
    mv_count = '0;
    mv_goal = '0;
    mv_up = '0;
    mv_down = '0;
    mv_speed = '0;
    mv_target = '0;
    mv_rise = '0;
    mv_fall = '0;
    mv_dir = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random_traffic();
    test_long_move();
    wait_idle();
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("[trapezoid_step_profile] OK");
    end else begin
      $display("[trapezoid_step_profile] ERROR");
    end
    $finish;
  end

endmodule

// ===== trapezoid_step_profile.f =====
rtl/tsp_pkg.sv
rtl/tsp_divider.sv
rtl/trapezoid_step_profile.sv
tb/trapezoid_step_profile_test.sv
